// ===== hdl/rsq_pkg.sv =====
// types, codes and reset values shared by the retry send queue
package rsq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [7:0]  DEF_RETRY_LIMIT        = 8'd3;
  localparam logic [15:0] DEF_START_DELAY        = 16'd30;
  localparam logic [15:0] DEF_RESEND_INTERVAL    = 16'd500;
  localparam logic [15:0] DEF_AFTER_REMOVE_DELAY = 16'd20;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    STS_QUEUED   = 3'd0,
    STS_FULL     = 3'd1,
    STS_REMOVED  = 3'd2,
    STS_NO_MATCH = 3'd3,
    STS_WAITING  = 3'd4,
    STS_TRANSMIT = 3'd5,
    STS_EXPIRED  = 3'd6,
    STS_STOPPED  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CFG_RETRY_LIMIT        = 2'd0,
    CFG_START_DELAY        = 2'd1,
    CFG_RESEND_INTERVAL    = 2'd2,
    CFG_AFTER_REMOVE_DELAY = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HEAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [7:0]  command_high;
    logic [7:0]  command_low;
    logic [15:0] dest_addr;
    logic [7:0]  seq_num;
    logic [7:0]  payload_handle;
    logic [7:0]  payload_len;
    logic        want_ack;
    logic        any_seq;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_command_high;
    logic [7:0]  out_command_low;
    logic [7:0]  out_payload_handle;
    logic [7:0]  out_payload_len;
  } rsp_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  seq;
    logic [7:0]  cmd_high;
    logic [7:0]  cmd_low;
    logic [7:0]  handle;
    logic [7:0]  len;
    logic [7:0]  tries;
    logic        ack;
  } entry_t;

endpackage

// ===== hdl/retry_send_queue_unit.sv =====
// retry send queue: message fifo with timed resend, retry limit and removal
//
// input channel in_valid/in_ready/in_data carries one request item: enqueue,
// remove matching, or a one millisecond tick. every item gives exactly one
// result item on out_valid/out_ready/out_data, in order.
// configuration is written on cfg_valid/cfg_ready with cfg_index and
// cfg_data (retry limit, start delay, resend interval, after-remove delay);
// cfg_ready is always high. the user must write it only while the block is
// idle; the block itself does not enforce this. enqueue, ignored requests
// and ticks that serve no head go from the exec state to the emit state; a
// tick that transmits the head passes the head state. a removal, or a tick
// that drops an exhausted head, compacts the queue with one read and at
// most one write of the two-port entry memory per cycle. one item is in
// work at a time; in_ready rises together with out_valid, so the next item
// can be taken at the edge that takes the result.
// reset (rst_n low, synchronous) empties the queue, stops the timer and
// loads the default register values; no clearing pass is run.
// when the receiver stalls, the result waits in the output register; the
// next item is still accepted and worked, and holds its result until the
// output register is free.
module retry_send_queue_unit #(
  parameter int QUEUE_DEPTH = rsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsq_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rsq_pkg::rsp_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import rsq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  state_t state_r, state_nxt;
  req_t   req_r, req_nxt;
  rsp_t   res_r, res_nxt;
  rsp_t   out_data_r, out_data_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic             timer_run_r, timer_run_nxt;
  logic [15:0]      countdown_r, countdown_nxt;

  logic [7:0]  retry_limit_r;
  logic [15:0] start_delay_r;
  logic [15:0] resend_interval_r;
  logic [15:0] after_remove_delay_r;

  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             hit_r, hit_nxt;
  logic             expire_r, expire_nxt;
  logic [15:0]      key_addr_r, key_addr_nxt;
  logic [7:0]       key_seq_r, key_seq_nxt;
  logic             key_any_r, key_any_nxt;

  entry_t     queue_mem_r [QUEUE_DEPTH];
  entry_t     rd_data_r;
  logic       mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t     mem_wdata;
  logic       mem_re;
  logic [IDX_W-1:0] mem_raddr;

  logic scan_done;
  logic emit_go;
  logic tick_serve;
  logic scan_match;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign scan_done  = (rd_ptr_r == occ_r) && !rd_vld_r;
  assign emit_go    = !out_valid_r || out_ready;
  assign tick_serve = timer_run_r && (countdown_r <= 16'd1) && (occ_r != '0);
  assign scan_match = (rd_data_r.addr == key_addr_r) &&
                      (key_any_r || (rd_data_r.seq == key_seq_r));

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      queue_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= queue_mem_r[mem_raddr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r        <= DEF_RETRY_LIMIT;
      start_delay_r        <= DEF_START_DELAY;
      resend_interval_r    <= DEF_RESEND_INTERVAL;
      after_remove_delay_r <= DEF_AFTER_REMOVE_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RETRY_LIMIT:        retry_limit_r        <= cfg_data[7:0];
        CFG_START_DELAY:        start_delay_r        <= cfg_data;
        CFG_RESEND_INTERVAL:    resend_interval_r    <= cfg_data;
        CFG_AFTER_REMOVE_DELAY: after_remove_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_r.req_type)
          REQ_REMOVE: state_nxt = ST_SCAN;
          REQ_TICK:   state_nxt = tick_serve ? ST_HEAD : ST_EMIT;
          default:    state_nxt = ST_EMIT;
        endcase
      end
      ST_HEAD: state_nxt = (rd_data_r.tries != 8'd0) ? ST_EMIT : ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    occ_nxt       = occ_r;
    timer_run_nxt = timer_run_r;
    countdown_nxt = countdown_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_vld_nxt    = 1'b0;
    hit_nxt       = hit_r;
    expire_nxt    = expire_r;
    key_addr_nxt  = key_addr_r;
    key_seq_nxt   = key_seq_r;
    key_any_nxt   = key_any_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = rd_data_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
        end
      end
      ST_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = STS_WAITING;
        unique case (req_r.req_type)
          REQ_ENQUEUE: begin
            if (occ_r == FULL_CNT) begin
              res_nxt.status = STS_FULL;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = occ_r[IDX_W-1:0];
              mem_wdata.addr     = req_r.dest_addr;
              mem_wdata.seq      = req_r.seq_num;
              mem_wdata.cmd_high = req_r.command_high;
              mem_wdata.cmd_low  = req_r.command_low;
              mem_wdata.handle   = req_r.payload_handle;
              mem_wdata.len      = req_r.payload_len;
              mem_wdata.tries    = req_r.want_ack ? retry_limit_r : 8'd1;
              mem_wdata.ack      = req_r.want_ack;
              occ_nxt            = occ_r + CNT_W'(1);
              if (!timer_run_r) begin
                timer_run_nxt = 1'b1;
                countdown_nxt = start_delay_r;
              end
              res_nxt.status = STS_QUEUED;
            end
          end
          REQ_REMOVE: begin
            key_addr_nxt = req_r.dest_addr;
            key_seq_nxt  = req_r.seq_num;
            key_any_nxt  = req_r.any_seq;
            rd_ptr_nxt   = '0;
            wr_ptr_nxt   = '0;
            hit_nxt      = 1'b0;
            expire_nxt   = 1'b0;
          end
          REQ_TICK: begin
            if (timer_run_r) begin
              if (countdown_r > 16'd1) begin
                countdown_nxt = countdown_r - 16'd1;
              end else if (occ_r == '0) begin
                timer_run_nxt  = 1'b0;
                countdown_nxt  = '0;
                res_nxt.status = STS_STOPPED;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
              end
            end
          end
          default: ;
        endcase
      end
      ST_HEAD: begin
        countdown_nxt = resend_interval_r;
        if (rd_data_r.tries != 8'd0) begin
          mem_we                     = 1'b1;
          mem_waddr                  = '0;
          mem_wdata.tries            = rd_data_r.tries - 8'd1;
          res_nxt.status             = STS_TRANSMIT;
          res_nxt.out_command_high   = rd_data_r.cmd_high;
          res_nxt.out_command_low    = rd_data_r.cmd_low;
          res_nxt.out_payload_handle = rd_data_r.handle;
          res_nxt.out_payload_len    = rd_data_r.len;
        end else begin
          key_addr_nxt = rd_data_r.addr;
          key_seq_nxt  = rd_data_r.seq;
          key_any_nxt  = rd_data_r.ack;
          rd_ptr_nxt   = '0;
          wr_ptr_nxt   = '0;
          hit_nxt      = 1'b0;
          expire_nxt   = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_vld_r) begin
          if (scan_match) begin
            hit_nxt = 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = wr_ptr_r[IDX_W-1:0];
            wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
          end
        end
        if (rd_ptr_r != occ_r) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r[IDX_W-1:0];
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          occ_nxt = wr_ptr_r;
          if (expire_r) begin
            res_nxt.status = STS_EXPIRED;
          end else if (hit_r) begin
            timer_run_nxt  = 1'b1;
            countdown_nxt  = after_remove_delay_r;
            res_nxt.status = STS_REMOVED;
          end else begin
            res_nxt.status = STS_NO_MATCH;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      timer_run_r <= 1'b0;
      countdown_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      occ_r       <= occ_nxt;
      timer_run_r <= timer_run_nxt;
      countdown_r <= countdown_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    hit_r      <= hit_nxt;
    expire_r   <= expire_nxt;
    key_addr_r <= key_addr_nxt;
    key_seq_r  <= key_seq_nxt;
    key_any_r  <= key_any_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("occupancy above queue depth");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> wr_ptr_r <= rd_ptr_r)
    else $error("compaction write pointer passed read pointer");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r > $past(occ_r) |-> occ_r == $past(occ_r) + CNT_W'(1))
    else $error("occupancy grew by more than one item");

  a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r != '0 |-> timer_run_r)
    else $error("queue holds entries with timer stopped");

endmodule

// ===== sim/tb.sv =====
// testbench for retry_send_queue_unit: directed and random requests checked against a queue predictor
`timescale 1ns / 100ps

module tb;
  import rsq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // predictor state
  entry_t      q_mem [QDEPTH];
  int unsigned q_count = 0;
  bit          tmr_on = 1'b0;
  logic [15:0] tmr_count = '0;
  logic [7:0]  lim_tries = DEF_RETRY_LIMIT;
  logic [15:0] dly_start = DEF_START_DELAY;
  logic [15:0] dly_resend = DEF_RESEND_INTERVAL;
  logic [15:0] dly_remove = DEF_AFTER_REMOVE_DELAY;

  rsp_t awaited_results [$];

  retry_send_queue_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic bit purge_entries(input logic [15:0] addr, input logic [7:0] seq,
                                       input bit any_seq);
    int unsigned keep;
    bit hit;
    keep = 0;
    hit = 1'b0;
    for (int unsigned i = 0; i < q_count; i++) begin
      if (q_mem[i].addr == addr && (any_seq || q_mem[i].seq == seq)) begin
        hit = 1'b1;
      end else begin
        q_mem[keep] = q_mem[i];
        keep++;
      end
    end
    q_count = keep;
    return hit;
  endfunction

  function automatic rsp_t queue_outcome(input req_t r);
    rsp_t res;
    res = '0;
    res.status = STS_WAITING;
    case (r.req_type)
      REQ_ENQUEUE: begin
        if (q_count >= QDEPTH) begin
          res.status = STS_FULL;
        end else begin
          q_mem[q_count].addr = r.dest_addr;
          q_mem[q_count].seq = r.seq_num;
          q_mem[q_count].cmd_high = r.command_high;
          q_mem[q_count].cmd_low = r.command_low;
          q_mem[q_count].handle = r.payload_handle;
          q_mem[q_count].len = r.payload_len;
          q_mem[q_count].tries = r.want_ack ? lim_tries : 8'd1;
          q_mem[q_count].ack = r.want_ack;
          q_count++;
          if (!tmr_on) begin
            tmr_on = 1'b1;
            tmr_count = dly_start;
          end
          res.status = STS_QUEUED;
        end
      end
      REQ_REMOVE: begin
        if (purge_entries(r.dest_addr, r.seq_num, r.any_seq)) begin
          tmr_on = 1'b1;
          tmr_count = dly_remove;
          res.status = STS_REMOVED;
        end else begin
          res.status = STS_NO_MATCH;
        end
      end
      REQ_TICK: begin
        if (tmr_on) begin
          if (tmr_count > 16'd1) begin
            tmr_count = tmr_count - 16'd1;
          end else if (q_count == 0) begin
            tmr_on = 1'b0;
            tmr_count = '0;
            res.status = STS_STOPPED;
          end else begin
            if (q_mem[0].tries != 8'd0) begin
              q_mem[0].tries = q_mem[0].tries - 8'd1;
              res.status = STS_TRANSMIT;
              res.out_command_high = q_mem[0].cmd_high;
              res.out_command_low = q_mem[0].cmd_low;
              res.out_payload_handle = q_mem[0].handle;
              res.out_payload_len = q_mem[0].len;
            end else begin
              void'(purge_entries(q_mem[0].addr, q_mem[0].seq, q_mem[0].ack));
              res.status = STS_EXPIRED;
            end
            tmr_count = dly_resend;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with none pending: status %0d", out_data.status);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", {5'b0, want.status}, {5'b0, out_data.status});
        check_field("out_command_high", want.out_command_high, out_data.out_command_high);
        check_field("out_command_low", want.out_command_low, out_data.out_command_low);
        check_field("out_payload_handle", want.out_payload_handle,
                    out_data.out_payload_handle);
        check_field("out_payload_len", want.out_payload_len, out_data.out_payload_len);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_req(input req_t r);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(queue_outcome(r));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_RETRY_LIMIT:        lim_tries = val[7:0];
      CFG_START_DELAY:        dly_start = val;
      CFG_RESEND_INTERVAL:    dly_resend = val;
      CFG_AFTER_REMOVE_DELAY: dly_remove = val;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] lim, input logic [15:0] start,
                          input logic [15:0] resend, input logic [15:0] after_rm);
    settle();
    write_reg(CFG_RETRY_LIMIT, {8'h00, lim});
    write_reg(CFG_START_DELAY, start);
    write_reg(CFG_RESEND_INTERVAL, resend);
    write_reg(CFG_AFTER_REMOVE_DELAY, after_rm);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t build_req(input req_kind_t kind, input logic [7:0] ch,
                                     input logic [7:0] cl, input logic [15:0] addr,
                                     input logic [7:0] seq, input logic [7:0] ph,
                                     input logic [7:0] pl, input bit ack, input bit any_seq);
    req_t r;
    r.req_type = kind;
    r.command_high = ch;
    r.command_low = cl;
    r.dest_addr = addr;
    r.seq_num = seq;
    r.payload_handle = ph;
    r.payload_len = pl;
    r.want_ack = ack;
    r.any_seq = any_seq;
    return r;
  endfunction

  function automatic logic [15:0] pool_addr();
    if ($urandom_range(7) == 0) return 16'($urandom);
    return 16'($urandom_range(3));
  endfunction

  function automatic logic [7:0] pool_seq();
    if ($urandom_range(7) == 0) return 8'($urandom);
    return 8'($urandom_range(3));
  endfunction

  function automatic req_t make_req(input int enq_pct, input int rem_pct);
    req_t r;
    logic [63:0] raw;
    int pick;
    int slot;
    raw = {$urandom, $urandom};
    r = raw[59:0];
    pick = $urandom_range(99);
    if (pick < 3) begin
      r.req_type = REQ_NONE;
    end else if (pick < 3 + enq_pct) begin
      r.req_type = REQ_ENQUEUE;
      r.dest_addr = pool_addr();
      r.seq_num = pool_seq();
    end else if (pick < 3 + enq_pct + rem_pct) begin
      r.req_type = REQ_REMOVE;
      if (q_count != 0 && $urandom_range(9) < 7) begin
        slot = $urandom_range(q_count - 1);
        r.dest_addr = q_mem[slot].addr;
        r.seq_num = ($urandom_range(3) == 0) ? pool_seq() : q_mem[slot].seq;
      end else begin
        r.dest_addr = pool_addr();
        r.seq_num = pool_seq();
      end
    end else begin
      r.req_type = REQ_TICK;
    end
    return r;
  endfunction

  task automatic run_random(input int count, input int enq_pct, input int rem_pct);
    for (int k = 0; k < count; k++) send_req(make_req(enq_pct, rem_pct));
  endtask

  task automatic test_directed();
    set_regs(8'd1, 16'd2, 16'd1, 16'd1);
    send_req(build_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_req(build_req(REQ_NONE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_req(build_req(REQ_REMOVE, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    send_req(build_req(REQ_ENQUEUE, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));
    send_req(build_req(REQ_ENQUEUE, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    // countdown, send head, drop head with its address, send, drop, stop
    repeat (6) begin
      send_req(build_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    end
    send_req(build_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_req(build_req(REQ_ENQUEUE, 8'h12, 8'h34, 16'h1234, 8'h05, 8'h56, 8'h78, 1'b0, 1'b0));
    send_req(build_req(REQ_ENQUEUE, 8'hA5, 8'h5A, 16'h1234, 8'h06, 8'h3C, 8'hC3, 1'b1, 1'b0));
    send_req(build_req(REQ_REMOVE, 8'h00, 8'h00, 16'h1234, 8'h05, 8'h00, 8'h00, 1'b0, 1'b0));
    send_req(build_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    // address-only removal empties the queue but still restarts the timer
    send_req(build_req(REQ_REMOVE, 8'h00, 8'h00, 16'h1234, 8'h63, 8'h00, 8'h00, 1'b0, 1'b1));
    send_req(build_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_req(build_req(REQ_REMOVE, 8'h00, 8'h00, 16'h1234, 8'h06, 8'h00, 8'h00, 1'b0, 1'b0));
  endtask

  task automatic test_retry_limit_zero();
    set_regs(8'd0, 16'd2, 16'd1, 16'd1);
    send_req(build_req(REQ_ENQUEUE, 8'h11, 8'h22, 16'h8001, 8'h07, 8'h33, 8'h44, 1'b1, 1'b0));
    send_req(build_req(REQ_ENQUEUE, 8'h55, 8'h66, 16'h8001, 8'h08, 8'h77, 8'h88, 1'b0, 1'b0));
    repeat (3) begin
      send_req(build_req(REQ_TICK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    end
  endtask

  task automatic test_fast_resend();
    set_regs(8'd3, 16'd1, 16'd1, 16'd1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(270, 30, 10);
  endtask

  task automatic test_sender_gaps();
    set_regs(8'd255, 16'd0, 16'd2, 16'd0);
    send_idle_pct = 65;
    recv_stall_pct = 0;
    run_random(270, 30, 10);
  endtask

  task automatic test_receiver_stall();
    set_regs(8'd1, 16'd3, 16'd4, 16'd2);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    run_random(270, 25, 10);
  endtask

  task automatic test_both_idle();
    set_regs(8'd2, 16'd5, 16'd3, 16'd7);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    run_random(270, 30, 12);
  endtask

  task automatic test_timer_extremes();
    set_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(150, 50, 20);
  endtask

  task automatic test_queue_full();
    set_regs(8'd4, 16'd2, 16'd1, 16'd3);
    send_idle_pct = 11;
    recv_stall_pct = 65;
    run_random(150, 65, 5);
  endtask

  task automatic test_reset_values();
    set_regs(DEF_RETRY_LIMIT, DEF_START_DELAY, DEF_RESEND_INTERVAL, DEF_AFTER_REMOVE_DELAY);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(150, 10, 5);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_retry_limit_zero();
    test_fast_resend();
    test_sender_gaps();
    test_receiver_stall();
    test_both_idle();
    test_timer_extremes();
    test_queue_full();
    test_reset_values();
    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== retry_send_queue_unit.f =====
hdl/rsq_pkg.sv
hdl/retry_send_queue_unit.sv
sim/tb.sv
